### rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; every use assumes a signal named clock, and TSD_ASSERT also reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every clock edge, reset included.
`define TSD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/tsd_pkg.sv
// Shared types, constants and helpers for the throw settle detector.
// No dependencies.
`timescale 1ns / 1ps

package tsd_pkg;

   // Field widths fixed by the frame format
   localparam int JERK_W   = 13;
   localparam int ENERGY_W = 26;
   localparam int DECAY_W  = 16;
   localparam int MSEC_W   = 16;
   localparam int FACE_W   = 12;
   localparam int TIME_W   = 32;
   localparam int PHASE_W  = 2;

   // Defaults for the top-level parameters
   localparam int ACCEL_BITS_DEF = 12;
   localparam int TIME_BITS_DEF  = 32;
   localparam int FIFO_DEPTH_DEF = 2;

   // CSR port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ENERGY_W;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_SLOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FAST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ROLL_MS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_LEVEL  = 3'd5;

   localparam logic [DECAY_W-1:0]  DECAY_SLOW_RST  = 16'd62259;
   localparam logic [DECAY_W-1:0]  DECAY_FAST_RST  = 16'd3277;
   localparam logic [ENERGY_W-1:0] START_LEVEL_RST = 26'd26214400;
   localparam logic [ENERGY_W-1:0] STOP_LEVEL_RST  = 26'd131072;
   localparam logic [MSEC_W-1:0]   MIN_ROLL_RST    = 16'd300;
   localparam logic [FACE_W-1:0]   FACE_LEVEL_RST  = 12'd435;

   // Motion phases
   localparam logic [PHASE_W-1:0] PH_REST  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_START = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LONG  = 2'd2;

   // Smoothing arithmetic: 26 x 17 shared multiplier, 42-bit accumulator
   localparam int MUL_A_W = ENERGY_W;
   localparam int MUL_B_W = DECAY_W + 1;
   localparam int ACC_W   = ENERGY_W + DECAY_W;
   localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(32768);
   localparam logic [MUL_B_W-1:0] ONE_Q16    = MUL_B_W'(65536);

   typedef struct packed {
      logic [DECAY_W-1:0]  decay_slow;
      logic [DECAY_W-1:0]  decay_fast;
      logic [ENERGY_W-1:0] start_level;
      logic [ENERGY_W-1:0] stop_level;
      logic [MSEC_W-1:0]   min_roll_ms;
      logic [FACE_W-1:0]   face_level;
   } cfg_type;

   // One classified frame as it sits in the queue
   typedef struct packed {
      logic [JERK_W-1:0] mag_x;
      logic [JERK_W-1:0] mag_y;
      logic [JERK_W-1:0] mag_z;
      logic              on_face;
      logic [TIME_W-1:0] now_ms;
   } item_type;

   // Magnitude of a jerk sample; full negative scale gives 4096
   function automatic logic [JERK_W-1:0] jerk_mag(input logic [JERK_W-1:0] v);
      logic [JERK_W-1:0] neg;
      neg = JERK_W'(~v + JERK_W'(1));
      return v[JERK_W-1] ? neg : v;
   endfunction

endpackage

### rtl/tsd_front.sv
// Front end: takes frames, forms jerk magnitudes and the face flag.
// Depends on tsd_pkg.
`timescale 1ns / 1ps

module tsd_front #(
   parameter int ACCEL_BITS = tsd_pkg::ACCEL_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tsd_pkg::JERK_W-1:0]       req_jerk_x,
   input  logic [tsd_pkg::JERK_W-1:0]       req_jerk_y,
   input  logic [tsd_pkg::JERK_W-1:0]       req_jerk_z,
   input  logic [ACCEL_BITS-1:0]            req_accel_x,
   input  logic [ACCEL_BITS-1:0]            req_accel_y,
   input  logic [ACCEL_BITS-1:0]            req_accel_z,
   input  logic [tsd_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [tsd_pkg::FACE_W-1:0]       face_level,
   output logic                             push,
   output tsd_pkg::item_type                push_item,
   input  logic                             queue_full
);
   import tsd_pkg::*;

   localparam int CMP_W = (ACCEL_BITS > FACE_W) ? ACCEL_BITS : FACE_W;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;
   logic [ACCEL_BITS-1:0] mag_ax, mag_ay, mag_az;
   logic [CMP_W-1:0]      face_cmp;

   function automatic logic [ACCEL_BITS-1:0] accel_mag(input logic [ACCEL_BITS-1:0] v);
      logic [ACCEL_BITS-1:0] neg;
      neg = ACCEL_BITS'(~v + ACCEL_BITS'(1));
      return v[ACCEL_BITS-1] ? neg : v;
   endfunction

   assign req_stall = valid_ff && queue_full;
   assign load      = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;
   assign push_item = item_ff;

   always_comb begin
      mag_ax   = accel_mag(req_accel_x);
      mag_ay   = accel_mag(req_accel_y);
      mag_az   = accel_mag(req_accel_z);
      face_cmp = CMP_W'(face_level);

      item_in.mag_x   = jerk_mag(req_jerk_x);
      item_in.mag_y   = jerk_mag(req_jerk_y);
      item_in.mag_z   = jerk_mag(req_jerk_z);
      item_in.on_face = (CMP_W'(mag_ax) > face_cmp) || (CMP_W'(mag_ay) > face_cmp) ||
                        (CMP_W'(mag_az) > face_cmp);
      item_in.now_ms  = req_now_ms;

      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

### rtl/tsd_queue.sv
// Short queue of classified frames between front end and back end.
// Depends on tsd_pkg.
`timescale 1ns / 1ps

module tsd_queue #(
   parameter int DEPTH = tsd_pkg::FIFO_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsd_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output tsd_pkg::item_type head_item
);
   import tsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST) ? '0 : PTR_W'(wr_ff + PTR_W'(1));
      end
      if (pop) begin
         rd_in = (rd_ff == LAST) ? '0 : PTR_W'(rd_ff + PTR_W'(1));
      end
      if (push && !pop) begin
         cnt_in = CNT_W'(cnt_ff + CNT_W'(1));
      end else if (pop && !push) begin
         cnt_in = CNT_W'(cnt_ff - CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

### rtl/tsd_back.sv
// Back end: energy smoothing on one shared multiplier, phase machine,
// result register. Depends on tsd_pkg.
`timescale 1ns / 1ps

module tsd_back #(
   parameter int TIME_BITS = tsd_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tsd_pkg::cfg_type              cfg,
   input  logic                          not_empty,
   input  tsd_pkg::item_type             head_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tsd_pkg::PHASE_W-1:0]   rsp_phase,
   output logic                          rsp_settled,
   output logic [tsd_pkg::ENERGY_W-1:0]  rsp_energy
);
   import tsd_pkg::*;

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Multiplier passes
   localparam logic [2:0] STEP_JX = 3'd0;
   localparam logic [2:0] STEP_JY = 3'd1;
   localparam logic [2:0] STEP_JZ = 3'd2;
   localparam logic [2:0] STEP_ED = 3'd3;
   localparam logic [2:0] STEP_JD = 3'd4;

   logic [1:0]          state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   item_type            item_ff;
   logic [ENERGY_W-1:0] j_ff, j_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]  rsp_phase_ff;
   logic                rsp_settled_ff, settled_in;
   logic [ENERGY_W-1:0] rsp_energy_ff;

   logic [DECAY_W-1:0]  decay;
   logic [MUL_A_W-1:0]  op_a;
   logic [MUL_B_W-1:0]  op_b;
   logic [MUL_A_W+MUL_B_W-1:0] prod;
   logic [ENERGY_W-1:0] new_e;
   logic [TIME_BITS-1:0] now_t, elapsed;
   logic                out_free, commit;

   assign decay   = (phase_ff == PH_LONG) ? cfg.decay_fast : cfg.decay_slow;
   assign new_e   = acc_ff[ACC_W-1:DECAY_W];
   assign now_t   = item_ff.now_ms[TIME_BITS-1:0];
   assign elapsed = TIME_BITS'(now_t - start_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit  = (state_ff == ST_DONE) && out_free;
   assign pop     = not_empty && ((state_ff == ST_IDLE) || commit);

   always_comb begin
      case (step_ff)
         STEP_JX: begin
            op_a = MUL_A_W'(item_ff.mag_x);
            op_b = MUL_B_W'(item_ff.mag_x);
         end
         STEP_JY: begin
            op_a = MUL_A_W'(item_ff.mag_y);
            op_b = MUL_B_W'(item_ff.mag_y);
         end
         STEP_JZ: begin
            op_a = MUL_A_W'(item_ff.mag_z);
            op_b = MUL_B_W'(item_ff.mag_z);
         end
         STEP_ED: begin
            op_a = energy_ff;
            op_b = MUL_B_W'(decay);
         end
         default: begin
            op_a = j_ff;
            op_b = MUL_B_W'(ONE_Q16 - MUL_B_W'(decay));
         end
      endcase
      prod = op_a * op_b;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      energy_in    = energy_ff;
      phase_in     = phase_ff;
      start_in     = start_ff;
      settled_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               state_in = ST_MUL;
               step_in  = STEP_JX;
            end
         end
         ST_MUL: begin
            step_in = 3'(step_ff + 3'd1);
            unique case (step_ff) inside
               STEP_JX: j_in = prod[ENERGY_W-1:0];
               STEP_JY, STEP_JZ: j_in = ENERGY_W'(j_ff + prod[ENERGY_W-1:0]);
               STEP_ED: acc_in = ACC_W'(prod[ACC_W-1:0] + ROUND_HALF);
               default: begin
                  acc_in   = ACC_W'(acc_ff + prod[ACC_W-1:0]);
                  state_in = ST_DONE;
               end
            endcase
         end
         default: begin
            if (commit) begin
               energy_in = new_e;
               unique case (phase_ff)
                  PH_START: begin
                     if (new_e < cfg.stop_level) begin
                        phase_in = PH_REST;
                     end else if (elapsed > TIME_BITS'(cfg.min_roll_ms)) begin
                        phase_in = PH_LONG;
                     end
                  end
                  PH_LONG: begin
                     if (new_e < cfg.stop_level) begin
                        phase_in   = PH_REST;
                        settled_in = item_ff.on_face;
                     end
                  end
                  default: begin
                     phase_in = PH_REST;
                     if (new_e >= cfg.start_level) begin
                        phase_in = PH_START;
                        start_in = now_t;
                     end
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = not_empty ? ST_MUL : ST_IDLE;
               step_in      = STEP_JX;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_JX;
         energy_ff    <= '0;
         phase_ff     <= PH_REST;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         energy_ff    <= energy_in;
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      acc_ff <= acc_in;
      if (pop) begin
         item_ff <= head_item;
      end
      if (commit) begin
         rsp_phase_ff   <= phase_in;
         rsp_settled_ff <= settled_in;
         rsp_energy_ff  <= new_e;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_phase   = rsp_phase_ff;
   assign rsp_settled = rsp_settled_ff;
   assign rsp_energy  = rsp_energy_ff;

endmodule

### rtl/throw_settle_detector_core.sv
// Top level of the throw settle detector: CSR bank, front end, queue, back end.
// Depends on tsd_pkg, tsd_front, tsd_queue and tsd_back.
`timescale 1ns / 1ps

// Die throw/settle detector. One transaction on the req_ channel carries one
// accelerometer frame (jerk, acceleration, millisecond time); each frame yields
// exactly one rsp_ transaction with the motion phase after the frame, the
// smoothed jerk energy and a settled flag for a long roll that ended with some
// axis above face_level. The back end sets the frame rate in steady state: it
// runs five passes through one shared 26x17 multiplier (three jerk squares,
// then the two halves of the exponential average) and one decision step per
// frame. The front register plus a FIFO_DEPTH-entry queue keep accepting
// frames while the back end works, and the result register lets the back end
// start the next frame while a result waits. CSR writes are always ready and
// are meant to happen only while the block is idle. No clearing pass after
// reset.

module throw_settle_detector_core #(
   parameter int ACCEL_BITS = tsd_pkg::ACCEL_BITS_DEF,
   parameter int TIME_BITS  = tsd_pkg::TIME_BITS_DEF,
   parameter int FIFO_DEPTH = tsd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // frame input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tsd_pkg::JERK_W-1:0]       req_jerk_x,
   input  logic [tsd_pkg::JERK_W-1:0]       req_jerk_y,
   input  logic [tsd_pkg::JERK_W-1:0]       req_jerk_z,
   input  logic [ACCEL_BITS-1:0]            req_accel_x,
   input  logic [ACCEL_BITS-1:0]            req_accel_y,
   input  logic [ACCEL_BITS-1:0]            req_accel_z,
   input  logic [tsd_pkg::TIME_W-1:0]       req_now_ms,
   // result output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tsd_pkg::PHASE_W-1:0]      rsp_phase,
   output logic                             rsp_settled,
   output logic [tsd_pkg::ENERGY_W-1:0]     rsp_energy,
   // CSR writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tsd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push, queue_full, pop, not_empty;
   item_type push_item, head_item;

   // CSR bank; writes to unused indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DECAY_SLOW:  cfg_in.decay_slow  = csr_wdata[DECAY_W-1:0];
            CSR_DECAY_FAST:  cfg_in.decay_fast  = csr_wdata[DECAY_W-1:0];
            CSR_START_LEVEL: cfg_in.start_level = csr_wdata[ENERGY_W-1:0];
            CSR_STOP_LEVEL:  cfg_in.stop_level  = csr_wdata[ENERGY_W-1:0];
            CSR_MIN_ROLL_MS: cfg_in.min_roll_ms = csr_wdata[MSEC_W-1:0];
            CSR_FACE_LEVEL:  cfg_in.face_level  = csr_wdata[FACE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_slow  <= DECAY_SLOW_RST;
         cfg_ff.decay_fast  <= DECAY_FAST_RST;
         cfg_ff.start_level <= START_LEVEL_RST;
         cfg_ff.stop_level  <= STOP_LEVEL_RST;
         cfg_ff.min_roll_ms <= MIN_ROLL_RST;
         cfg_ff.face_level  <= FACE_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: magnitudes and face flag, one frame register
   tsd_front #(
      .ACCEL_BITS (ACCEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_jerk_x  (req_jerk_x),
      .req_jerk_y  (req_jerk_y),
      .req_jerk_z  (req_jerk_z),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .req_now_ms  (req_now_ms),
      .face_level  (cfg_ff.face_level),
      .push        (push),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   // Decoupling queue
   tsd_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   // Back end: smoothing, phase machine, result register
   tsd_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .not_empty   (not_empty),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_phase   (rsp_phase),
      .rsp_settled (rsp_settled),
      .rsp_energy  (rsp_energy)
   );

endmodule

### rtl/tsd_checker.sv
// Port-level checks for the throw settle detector, bound to the top level.
// Depends on tsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [tsd_pkg::PHASE_W-1:0]      rsp_phase,
   input logic                             rsp_settled,
   input logic [tsd_pkg::ENERGY_W-1:0]     rsp_energy
);
   import tsd_pkg::*;

   logic held;
   assign held = rsp_valid && rsp_stall;

   `TSD_ASSERT(a_rsp_hold, held |=> rsp_valid, "rsp_valid dropped while stalled")
   `TSD_ASSERT(a_rsp_stable, held |=> $stable(rsp_energy) && $stable(rsp_phase), "stalled rsp changed")
   `TSD_ASSERT(a_settle_rest, rsp_valid && rsp_settled |-> rsp_phase == PH_REST, "settle without rest")
   `TSD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp_valid right after reset")

endmodule

bind throw_settle_detector_core tsd_checker u_tsd_checker (.*);
